### rtl/orbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orbm_pkg - shared constants, types and index helpers
// Ring geometry, operation codes and the request/response bundles between
// the top level and the find engine.
// ----------------------------------------------------------------------------
package orbm_pkg;

	localparam int BUF_BYTES = 512;
	localparam int IDX_W     = $clog2(BUF_BYTES);
	localparam int MAX_PAT   = 8;
	localparam int PAT_W     = 64;
	localparam int PLEN_W    = 4;
	localparam int CNT_W     = $clog2(MAX_PAT + 1);
	localparam int PSEL_W    = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
	localparam int OFS_W     = 9;
	localparam int AVAIL_W   = 9;
	localparam int BYTE_W    = 8;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_DRAIN = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_FIND  = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic             start;
		idx_t             base;
		idx_t             count;
		logic [PAT_W-1:0] pattern;
		logic [CNT_W-1:0] plen;
	} find_req_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic              rd_en;
		idx_t              rd_addr;
	} find_rsp_t;

	function automatic idx_t idx_inc(input idx_t a);
		idx_t r;
		if (a == IDX_W'(BUF_BYTES - 1)) begin
			r = '0;
		end else begin
			r = a + idx_t'(1);
		end
		return r;
	endfunction

	function automatic idx_t idx_add(input idx_t a, input idx_t b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(BUF_BYTES)) begin
			s = s - (IDX_W+1)'(BUF_BYTES);
		end
		return s[IDX_W-1:0];
	endfunction

	// (a - b) mod ring size
	function automatic idx_t idx_sub(input idx_t a, input idx_t b);
		logic [IDX_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + (IDX_W+1)'(BUF_BYTES) - {1'b0, b};
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/orbm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orbm_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module orbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/orbm_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orbm_find - pattern search engine
// Streams the held bytes oldest first through an eight-byte window and runs
// one shared masked compare against the aligned pattern after every shift.
// ----------------------------------------------------------------------------
module orbm_find (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire orbm_pkg::find_req_t req,
	input  wire logic [7:0]          rd_data,
	output orbm_pkg::find_rsp_t      rsp
);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_RUN  = 1'b1;

	logic                        fstate_q;
	orbm_pkg::idx_t              addr_q;
	orbm_pkg::idx_t              rem_q;
	logic                        pend_s1;
	logic                        new_q;
	logic [orbm_pkg::CNT_W-1:0]  fill_q;
	logic [orbm_pkg::CNT_W-1:0]  plen_q;
	logic                        found_q;
	logic [7:0]                  win_q  [orbm_pkg::MAX_PAT];
	logic [7:0]                  apat_q [orbm_pkg::MAX_PAT];
	logic [7:0]                  apat_d [orbm_pkg::MAX_PAT];
	logic                        issue;
	logic                        done;
	logic                        hit;

	// window slot i holds the byte read i shifts ago; pattern byte plen-1-i
	// lines up with it
	always_comb begin
		for (int i = 0; i < orbm_pkg::MAX_PAT; i++) begin
			if (orbm_pkg::CNT_W'(i) < req.plen) begin
				apat_d[i] = req.pattern[8*(32'(req.plen) - 1 - i) +: 8];
			end else begin
				apat_d[i] = '0;
			end
		end
	end

	// shared compare unit
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < orbm_pkg::MAX_PAT; i++) begin
			if (orbm_pkg::CNT_W'(i) < plen_q && win_q[i] != apat_q[i]) begin
				hit = 1'b0;
			end
		end
	end

	assign issue = (fstate_q == F_RUN) && (rem_q != '0);
	assign done  = (fstate_q == F_RUN) && (rem_q == '0) && !pend_s1 && !new_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= F_IDLE;
			rem_q    <= '0;
			pend_s1  <= 1'b0;
			new_q    <= 1'b0;
			fill_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			new_q   <= pend_s1;
			case (fstate_q)
				F_IDLE: begin
					if (req.start) begin
						fstate_q <= F_RUN;
						rem_q    <= req.count;
						fill_q   <= '0;
						found_q  <= 1'b0;
					end
				end
				F_RUN: begin
					if (issue) begin
						rem_q <= rem_q - orbm_pkg::idx_t'(1);
					end
					if (pend_s1 && fill_q != orbm_pkg::CNT_W'(orbm_pkg::MAX_PAT)) begin
						fill_q <= fill_q + orbm_pkg::CNT_W'(1);
					end
					if (new_q && fill_q >= plen_q && hit) begin
						found_q <= 1'b1;
					end
					if (done) begin
						fstate_q <= F_IDLE;
					end
				end
				default: begin
					fstate_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fstate_q == F_IDLE && req.start) begin
			addr_q <= req.base;
			plen_q <= req.plen;
			apat_q <= apat_d;
		end else if (issue) begin
			addr_q <= orbm_pkg::idx_inc(addr_q);
		end
		if (pend_s1) begin
			win_q[0] <= rd_data;
			for (int i = 1; i < orbm_pkg::MAX_PAT; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	assign rsp.done    = done;
	assign rsp.found   = found_q;
	assign rsp.rd_en   = issue;
	assign rsp.rd_addr = addr_q;

endmodule
`default_nettype wire

### rtl/overwrite_ring_buffer_with_match_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_with_match_core - byte ring with peek and find
// Overwrite-oldest receive ring: put, drain, peek at offset, find pattern.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                             | tuser
//  ---------+-----+------------------------------------------------+-----------
//  s_*      | in  | data_byte, peek_offset, pattern, pattern_length | operation
//  m_*      | out | available, peek_byte, peek_valid, found         | -
//
//  Put and drain answer from the result register; puts stream one per cycle
//  while m_tready is high. Peek passes the registered RAM read and the peek
//  state. Find streams the held bytes oldest first, one byte per cycle into
//  the compare window; a zero length or one above the held count skips the
//  walk. s_tready is low while a peek or find runs or an untaken result
//  waits. Reset leaves the store alone; it is never read outside the held range.
//
module overwrite_ring_buffer_with_match_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] data_byte, [16:8] peek_offset, [80:17] pattern,
	// [84:81] pattern_length, [87:85] zero
	input  wire logic [87:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [8:0] available, [16:9] peek_byte, [17] peek_valid, [18] found,
	// [23:19] zero
	output logic [23:0]      m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PEEK = 2'd1;
	localparam logic [1:0] ST_FIND = 2'd2;

	// request fields
	logic [7:0]                    data_byte;
	logic [orbm_pkg::OFS_W-1:0]    peek_offset;
	logic [orbm_pkg::PAT_W-1:0]    pattern;
	logic [orbm_pkg::PLEN_W-1:0]   pattern_length;
	logic [1:0]                    operation;

	assign data_byte      = s_tdata[7:0];
	assign peek_offset    = s_tdata[16:8];
	assign pattern        = s_tdata[80:17];
	assign pattern_length = s_tdata[84:81];
	assign operation      = s_tuser;

	logic [1:0]                    state_q;
	orbm_pkg::idx_t                wr_q;
	orbm_pkg::idx_t                rd_q;

	// output register
	logic                          out_vld_q;
	orbm_pkg::idx_t                avail_q;
	logic [7:0]                    pbyte_q;
	logic                          pvalid_q;
	logic                          found_q;

	logic                          accept;
	logic                          out_free;
	orbm_pkg::idx_t                held;
	orbm_pkg::idx_t                wr_nxt;
	orbm_pkg::idx_t                rd_nxt;
	orbm_pkg::idx_t                peek_addr;
	logic                          peek_ok;
	logic [orbm_pkg::CNT_W-1:0]    plen_sat;
	logic                          find_short;
	logic                          find_run;

	logic                          ram_we;
	logic                          ram_re;
	orbm_pkg::idx_t                ram_raddr;
	logic [7:0]                    ram_rdata;

	orbm_pkg::find_req_t           freq;
	orbm_pkg::find_rsp_t           frsp;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign held = orbm_pkg::idx_sub(wr_q, rd_q);

	// put: advance write side, drop oldest when the ring fills
	always_comb begin
		wr_nxt = orbm_pkg::idx_inc(wr_q);
		if (wr_nxt == rd_q) begin
			rd_nxt = orbm_pkg::idx_inc(rd_q);
		end else begin
			rd_nxt = rd_q;
		end
	end

	assign peek_ok   = 32'(peek_offset) < 32'(held);
	assign peek_addr = orbm_pkg::idx_add(rd_q, orbm_pkg::IDX_W'(peek_offset));

	// lengths above the pattern capacity saturate
	assign plen_sat = (32'(pattern_length) > orbm_pkg::MAX_PAT)
		? orbm_pkg::CNT_W'(orbm_pkg::MAX_PAT) : orbm_pkg::CNT_W'(pattern_length);
	// zero length or longer than held: answer without a walk
	assign find_short = (plen_sat == '0) || (32'(plen_sat) > 32'(held));
	assign find_run   = accept && operation == orbm_pkg::OP_FIND && !find_short;

	assign freq.start   = find_run;
	assign freq.base    = rd_q;
	assign freq.count   = held;
	assign freq.pattern = pattern;
	assign freq.plen    = plen_sat;

	assign ram_we    = accept && operation == orbm_pkg::OP_PUT;
	assign ram_re    = (accept && operation == orbm_pkg::OP_PEEK && peek_ok) || frsp.rd_en;
	assign ram_raddr = (state_q == ST_FIND) ? frsp.rd_addr : peek_addr;

	orbm_ram #(
		.WIDTH (orbm_pkg::BYTE_W),
		.DEPTH (orbm_pkg::BUF_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	orbm_find u_find (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (freq),
		.rd_data (ram_rdata),
		.rsp     (frsp)
	);

	// sequencer, indices and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_q      <= '0;
			rd_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							orbm_pkg::OP_PUT: begin
								wr_q      <= wr_nxt;
								rd_q      <= rd_nxt;
								out_vld_q <= 1'b1;
							end
							orbm_pkg::OP_DRAIN: begin
								rd_q      <= wr_q;
								out_vld_q <= 1'b1;
							end
							orbm_pkg::OP_PEEK: begin
								if (peek_ok) begin
									state_q <= ST_PEEK;
								end else begin
									out_vld_q <= 1'b1;
								end
							end
							default: begin
								if (find_short) begin
									out_vld_q <= 1'b1;
								end else begin
									state_q <= ST_FIND;
								end
							end
						endcase
					end
				end
				ST_PEEK: begin
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_FIND: begin
					if (frsp.done) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			pbyte_q  <= '0;
			pvalid_q <= 1'b0;
			found_q  <= 1'b0;
			case (operation)
				orbm_pkg::OP_PUT: begin
					avail_q <= orbm_pkg::idx_sub(wr_nxt, rd_nxt);
				end
				orbm_pkg::OP_DRAIN: begin
					avail_q <= '0;
				end
				orbm_pkg::OP_PEEK: begin
					avail_q <= held;
				end
				default: begin
					avail_q <= held;
					found_q <= (plen_sat == '0);
				end
			endcase
		end else if (state_q == ST_PEEK) begin
			pbyte_q  <= ram_rdata;
			pvalid_q <= 1'b1;
		end else if (state_q == ST_FIND && frsp.done) begin
			found_q <= frsp.found;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, found_q, pvalid_q, pbyte_q, orbm_pkg::AVAIL_W'(avail_q)};

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for overwrite_ring_buffer_with_match_core
// Sends put, drain, peek and find requests over the slave stream, predicts
// each response with a local ring model and checks every response field.
// ----------------------------------------------------------------------------
module tb_top;
	import orbm_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int TIMEOUT_CYCLES = 3000000;
	// a find on a full ring walks every held byte
	localparam int SETTLE_CYCLES  = BUF_BYTES + 16;

	typedef struct {
		logic [AVAIL_W-1:0] avail;
		logic [BYTE_W-1:0]  peek_byte;
		logic               peek_valid;
		logic               found;
	} ring_rsp_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = OP_PUT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	overwrite_ring_buffer_with_match_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// ring model: its own copy of the store and both indices
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] ring_bytes [BUF_BYTES];
	int ring_wr = 0;
	int ring_rd = 0;
	int ring_drops = 0;     // puts that pushed out the oldest byte

	ring_rsp_t rsp_queue [$];   // predicted responses, oldest first

	int errors        = 0;
	int rsp_checked   = 0;
	int cycle_count   = 0;
	int req_count [4] = '{0, 0, 0, 0};
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic int ring_held();
		return (ring_wr + BUF_BYTES - ring_rd) % BUF_BYTES;
	endfunction

	function automatic logic [BYTE_W-1:0] ring_at(input int ofs_from_rd);
		return ring_bytes[(ring_rd + ofs_from_rd) % BUF_BYTES];
	endfunction

	// Apply one accepted request to the model and return its response.
	function automatic ring_rsp_t ring_apply(input logic [1:0] op,
		input logic [7:0] data, input logic [8:0] ofs,
		input logic [63:0] pat, input logic [3:0] plen);
		ring_rsp_t r;
		int len;
		int n;
		int s;
		int j;
		bit hit;
		r.peek_byte  = '0;
		r.peek_valid = 1'b0;
		r.found      = 1'b0;
		case (op)
			OP_PUT: begin
				ring_bytes[ring_wr] = data;
				ring_wr = (ring_wr + 1) % BUF_BYTES;
				// write caught up with read: drop the oldest byte
				if (ring_wr == ring_rd) begin
					ring_rd = (ring_rd + 1) % BUF_BYTES;
					ring_drops++;
				end
			end
			OP_DRAIN: begin
				ring_rd = ring_wr;
			end
			OP_PEEK: begin
				if (int'(ofs) < ring_held()) begin
					r.peek_byte  = ring_at(int'(ofs));
					r.peek_valid = 1'b1;
				end
			end
			OP_FIND: begin
				// oversize lengths clamp; zero length matches at start 0
				len = (int'(plen) > MAX_PAT) ? MAX_PAT : int'(plen);
				n   = ring_held();
				for (s = 0; s + len <= n && !r.found; s++) begin
					hit = 1'b1;
					for (j = 0; j < len; j++) begin
						if (ring_at(s + j) != pat[8*j +: 8]) begin
							hit = 1'b0;
						end
					end
					r.found = hit;
				end
			end
		endcase
		r.avail = AVAIL_W'(ring_held());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// request side: drive at falling edge, accept at rising edge
	// ------------------------------------------------------------------
	// Valid stays high after an accept; the next call either reloads it or
	// drops it at the following falling edge, never both in one step.
	task automatic send_request(input logic [1:0] op, input logic [7:0] data,
		input logic [8:0] ofs, input logic [63:0] pat, input logic [3:0] plen);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, plen, pat, ofs, data};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		rsp_queue.push_back(ring_apply(op, data, ofs, pat, plen));
		req_count[op]++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// fields an operation does not use are always random
	task automatic put_byte(input logic [7:0] data);
		send_request(OP_PUT, data, 9'($urandom), rand64(), 4'($urandom));
	endtask

	task automatic drain_ring();
		send_request(OP_DRAIN, 8'($urandom), 9'($urandom), rand64(), 4'($urandom));
	endtask

	task automatic peek_at(input logic [8:0] ofs);
		send_request(OP_PEEK, 8'($urandom), ofs, rand64(), 4'($urandom));
	endtask

	task automatic find_pattern(input logic [63:0] pat, input logic [3:0] plen);
		send_request(OP_FIND, 8'($urandom), 9'($urandom), pat, plen);
	endtask

	// ------------------------------------------------------------------
	// response side: random back-pressure, check on every transfer
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		ring_rsp_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (rsp_queue.size() == 0) begin
				$display("%0t ns: response with no request pending, expected none, actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				want = rsp_queue.pop_front();
				check_field("available",  want.avail,      m_tdata[8:0]);
				check_field("peek_byte",  want.peek_byte,  m_tdata[16:9]);
				check_field("peek_valid", want.peek_valid, m_tdata[17]);
				check_field("found",      want.found,      m_tdata[18]);
				rsp_checked++;
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("Timeout at cycle %0d, %0d responses still pending",
				cycle_count, rsp_queue.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// empty ring: zero-length find hits, anything else misses or is invalid
	task automatic test_empty_ring();
		find_pattern(rand64(), 4'd0);
		find_pattern(rand64(), 4'd1);
		peek_at(9'd0);
		drain_ring();
	endtask

	// small fills with the byte extremes, peeks at the edges, finds of every
	// length class including an oversize one
	task automatic test_put_peek_find();
		logic [63:0] held8;
		put_byte(8'h00);
		put_byte(8'hFF);
		peek_at(9'd0);
		peek_at(9'd1);
		peek_at(9'd2);              // just past the newest byte
		peek_at(9'h1FF);            // far out of range
		find_pattern({48'hA5A5_5A5A_C3C3, 16'hFF00}, 4'd2);
		find_pattern(rand64(), 4'd3);   // longer than what is held
		put_byte(8'hA5);
		put_byte(8'h5A);
		put_byte(8'h01);
		put_byte(8'h80);
		put_byte(8'h7E);
		put_byte(8'hC3);
		held8 = 64'hC37E_8001_5AA5_FF00;
		find_pattern(held8, 4'd8);
		find_pattern(held8, 4'd15);     // clamps to eight bytes
		find_pattern(held8 ^ 64'h8000_0000_0000_0000, 4'd8);
		find_pattern(rand64(), 4'd0);
		peek_at(9'd7);
		drain_ring();
		peek_at(9'd0);
	endtask

	// fill to capacity, keep putting so each put drops the oldest byte
	task automatic test_overwrite_when_full();
		int span;
		int j;
		logic [63:0] pat;
		drain_ring();
		while (ring_held() < BUF_BYTES - 1) begin
			put_byte(8'($urandom));
			if ($urandom_range(63) == 0) begin
				peek_at(9'($urandom_range(ring_held() - 1)));
			end
		end
		peek_at(9'(BUF_BYTES - 2));     // newest byte of a full ring
		peek_at(9'(BUF_BYTES - 1));     // one past it
		// pattern straddling the physical end of the store
		span = (2 * BUF_BYTES - 4 - ring_rd) % BUF_BYTES;
		if (span > BUF_BYTES - 1 - MAX_PAT) begin
			span = 0;
		end
		pat = rand64();
		for (j = 0; j < MAX_PAT; j++) begin
			pat[8*j +: 8] = ring_at(span + j);
		end
		find_pattern(pat, 4'(MAX_PAT));
		repeat (24) begin
			put_byte(8'($urandom));
			peek_at(9'd0);
		end
		find_pattern(rand64(), 4'(MAX_PAT));  // almost surely a full walk and miss
		drain_ring();
	endtask

	// mostly well-formed traffic: put bursts, in-range peeks, finds cut from
	// the held bytes (some with one byte spoiled), plus drains and noise
	task automatic test_mixed_traffic(input int n_items);
		int sent;
		int held;
		int kind;
		int burst;
		int start;
		int len;
		int j;
		logic [63:0] pat;
		sent = 0;
		while (sent < n_items) begin
			held = ring_held();
			kind = $urandom_range(99);
			if (held > 48 && $urandom_range(3) == 0) begin
				drain_ring();           // keeps finds short
				sent++;
			end else if (kind < 40) begin
				burst = $urandom_range(12, 1);
				repeat (burst) begin
					put_byte(8'($urandom));
				end
				sent += burst;
			end else if (kind < 62) begin
				if (held > 0 && $urandom_range(4) != 0) begin
					peek_at(9'($urandom_range(held - 1)));
				end else begin
					peek_at(9'($urandom));
				end
				sent++;
			end else if (kind < 88) begin
				if (held > 0 && $urandom_range(3) != 0) begin
					start = $urandom_range(held - 1);
					len = $urandom_range((held - start < MAX_PAT) ? held - start : MAX_PAT, 1);
					pat = rand64();
					for (j = 0; j < len; j++) begin
						pat[8*j +: 8] = ring_at(start + j);
					end
					if ($urandom_range(3) == 0) begin
						pat[8*$urandom_range(len - 1) +: 8] ^= 8'($urandom_range(255, 1));
					end
					find_pattern(pat, 4'(len));
				end else begin
					find_pattern(rand64(), 4'($urandom_range(15)));
				end
				sent++;
			end else if (kind < 93) begin
				drain_ring();
				sent++;
			end else begin
				send_request(2'($urandom), 8'($urandom), 9'($urandom), rand64(),
					4'($urandom));
				sent++;
			end
		end
	endtask

	// drop valid, let every response arrive, then watch for strays
	task automatic wait_for_responses();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (rsp_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
	endtask

	initial begin
		send_idle_pct = 20;
		recv_idle_pct = 65;
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_ring();
		test_put_peek_find();
		test_mixed_traffic(90);

		send_idle_pct = 65;
		recv_idle_pct = 20;
		test_overwrite_when_full();
		test_mixed_traffic(90);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_mixed_traffic(90);

		wait_for_responses();
		$display("Ran %0d puts (%0d dropped the oldest byte), %0d drains, %0d peeks, %0d finds",
			req_count[OP_PUT], ring_drops, req_count[OP_DRAIN], req_count[OP_PEEK],
			req_count[OP_FIND]);
		$display("%0d responses checked over three idle mixes, %0d mismatches",
			rsp_checked, errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
